FILE: sv/priority_scheduler_with_aging_macros.svh
// Assertion helpers for the scheduler datapath (psa_dp).
`ifndef PRIORITY_SCHEDULER_WITH_AGING_MACROS_SVH
`define PRIORITY_SCHEDULER_WITH_AGING_MACROS_SVH

`ifndef SYNTH
`define PSA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psa check failed");
`define PSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psa check failed");
`else
`define PSA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PSA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: sv/psa_pkg.sv
package psa_pkg;

    localparam int MAX_JOBS_DEF = 32;
    localparam int LEVELS_DEF   = 4;
    localparam int ID_W         = 5;
    localparam int ID_SPACE     = 32;
    localparam int PRIO_W       = 3;
    localparam int RT_W         = 8;
    localparam int TIME_W       = 14;
    localparam int THR_W        = 4;

    localparam logic [THR_W-1:0]  WAIT_MAX     = 4'd15;
    localparam logic [THR_W-1:0]  THR_RESET    = 4'd5;
    localparam logic [TIME_W-1:0] CUTOFF_RESET = 14'd99;
    localparam logic [TIME_W-1:0] TIME_MAX     = 14'h3FFF;

    localparam logic CMD_ARRIVE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_CUTOFF    = 1'b1;

    typedef struct packed {
        logic              command;
        logic [ID_W-1:0]   job_id;
        logic [PRIO_W-1:0] job_priority;
        logic [RT_W-1:0]   job_runtime;
    } in_word_t;

    typedef struct packed {
        logic [TIME_W-1:0] tick_time;
        logic              cpu_busy;
        logic [ID_W-1:0]   running_job;
        logic              job_started;
        logic              job_completed;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PICK_RD,
        ST_PICK_WB,
        ST_RUN,
        ST_AGE_RD,
        ST_AGE_WB,
        ST_PROM_RD,
        ST_PROM_WB,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic arrive;
        logic tick_start;
        logic pick_rd;
        logic pick_wb;
        logic run;
        logic age_rd;
        logic age_wb;
        logic age_next_lv;
        logic prom_rd;
        logic prom_wb;
        logic prom_next_lv;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic need_pick;
        logic age_more;
        logic prom_more;
        logic lv_last;
        logic out_free;
    } dp_stat_t;

endpackage

FILE: sv/priority_scheduler_with_aging.sv
// channel  dir  handshake                 payload
// s_       in   s_valid / s_ready         in_word_t: command, job, priority, runtime
// m_       out  m_valid / m_ready         out_word_t: one word per tick
// apb      in   psel / penable / pwrite   0x0 aging_threshold, 0x4 arrival_cutoff
//
// Arrival: accepted in the idle state. Tick: pick (CPU idle, job queued), run, aging
// over queued entries, promotion over levels 2 and below (each entry read from the RAM,
// then updated), output load. Synchronous active-low reset empties all levels.
// A pending m_ word holds the next tick at its last step; arrivals still go in.
module priority_scheduler_with_aging #(
    parameter int MAX_JOBS = psa_pkg::MAX_JOBS_DEF,
    parameter int LEVELS   = psa_pkg::LEVELS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  psa_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output psa_pkg::out_word_t m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import psa_pkg::*;

    logic [THR_W-1:0]  thr_reg;
    logic [TIME_W-1:0] cutoff_reg;
    dp_cmd_t           cmd;
    dp_stat_t          stat;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg    <= THR_RESET;
            cutoff_reg <= CUTOFF_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_THRESHOLD) begin
                thr_reg <= pwdata[THR_W-1:0];
            end else begin
                cutoff_reg <= pwdata[TIME_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_CUTOFF) ? {{(32-TIME_W){1'b0}}, cutoff_reg}
                                             : {{(32-THR_W){1'b0}}, thr_reg};

    psa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    psa_dp #(
        .MAX_JOBS (MAX_JOBS),
        .LEVELS   (LEVELS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_data          (s_data),
        .aging_threshold (thr_reg),
        .arrival_cutoff  (cutoff_reg),
        .cmd             (cmd),
        .stat            (stat),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data)
    );

endmodule

FILE: sv/psa_ram.sv
module psa_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/psa_ctrl.sv
module psa_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  psa_pkg::dp_stat_t stat,
    output psa_pkg::dp_cmd_t  cmd
);
    import psa_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && stat.is_tick) begin
                    state_next = stat.need_pick ? ST_PICK_RD : ST_RUN;
                end
            end
            ST_PICK_RD: state_next = ST_PICK_WB;
            ST_PICK_WB: state_next = ST_RUN;
            ST_RUN:     state_next = ST_AGE_RD;
            ST_AGE_RD: begin
                if (stat.age_more) begin
                    state_next = ST_AGE_WB;
                end else if (stat.lv_last) begin
                    state_next = ST_PROM_RD;
                end
            end
            ST_AGE_WB: state_next = ST_AGE_RD;
            ST_PROM_RD: begin
                if (stat.prom_more) begin
                    state_next = ST_PROM_WB;
                end else if (stat.lv_last) begin
                    state_next = ST_FIN;
                end
            end
            ST_PROM_WB: state_next = ST_PROM_RD;
            ST_FIN: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready         = 1'b1;
                cmd.tick_start  = s_valid && stat.is_tick;
                cmd.arrive      = s_valid && !stat.is_tick;
            end
            ST_PICK_RD: cmd.pick_rd = 1'b1;
            ST_PICK_WB: cmd.pick_wb = 1'b1;
            ST_RUN:     cmd.run     = 1'b1;
            ST_AGE_RD: begin
                cmd.age_rd      = stat.age_more;
                cmd.age_next_lv = !stat.age_more;
            end
            ST_AGE_WB:  cmd.age_wb = 1'b1;
            ST_PROM_RD: begin
                cmd.prom_rd      = stat.prom_more;
                cmd.prom_next_lv = !stat.prom_more && !stat.lv_last;
            end
            ST_PROM_WB: cmd.prom_wb  = 1'b1;
            ST_FIN:     cmd.out_load = stat.out_free;
            default:    cmd = '0;
        endcase
    end

endmodule

FILE: sv/psa_dp.sv
`include "priority_scheduler_with_aging_macros.svh"

module psa_dp #(
    parameter int MAX_JOBS = psa_pkg::MAX_JOBS_DEF,
    parameter int LEVELS   = psa_pkg::LEVELS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  psa_pkg::in_word_t           s_data,
    input  logic [psa_pkg::THR_W-1:0]   aging_threshold,
    input  logic [psa_pkg::TIME_W-1:0]  arrival_cutoff,
    input  psa_pkg::dp_cmd_t            cmd,
    output psa_pkg::dp_stat_t           stat,
    output logic                        m_valid,
    input  logic                        m_ready,
    output psa_pkg::out_word_t          m_data
);
    import psa_pkg::*;

    localparam int PW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CW = $clog2(MAX_JOBS + 1);
    localparam int LW = $clog2(LEVELS);
    localparam int AW = LW + PW;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_JOBS);
    localparam logic [LW-1:0] LV_LAST = LW'(LEVELS - 1);

    function automatic logic [PW-1:0] wrap_ptr(input logic [PW:0] s);
        logic [PW:0] r;
        r = (s >= (PW+1)'(MAX_JOBS)) ? s - (PW+1)'(MAX_JOBS) : s;
        return r[PW-1:0];
    endfunction

    logic [PW-1:0]    head_reg  [LEVELS];
    logic [PW-1:0]    head_next [LEVELS];
    logic [CW-1:0]    count_reg [LEVELS];
    logic [CW-1:0]    count_next[LEVELS];
    logic [THR_W-1:0] wait_reg  [ID_SPACE];
    logic [THR_W-1:0] wait_next [ID_SPACE];
    logic [RT_W-1:0]  rt_reg    [ID_SPACE];

    logic              busy_reg;
    logic [ID_W-1:0]   cur_reg;
    logic [RT_W-1:0]   quanta_reg;
    logic [TIME_W-1:0] time_reg;
    logic              started_reg;
    logic              res_busy_reg;
    logic              res_done_reg;
    logic [LW-1:0]     lv_reg;
    logic [CW-1:0]     k_reg;
    logic [CW-1:0]     n_reg;
    logic              m_valid_reg;
    out_word_t         m_data_reg;

    logic [LW-1:0]   sel_lv;
    logic            any_queued;
    logic [LW-1:0]   arr_lv;
    logic            arr_ok;
    logic            promote;
    logic [LW-1:0]   dst_lv;
    logic [ID_W-1:0] rd_id;
    logic [RT_W-1:0] quanta_dec;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [ID_W-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [ID_W-1:0] ram_rdata;

    psa_ram #(
        .WIDTH (ID_W),
        .DEPTH (1 << AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_id = ram_rdata;

    always_comb begin
        sel_lv     = '0;
        any_queued = 1'b0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (count_reg[i] != '0) begin
                sel_lv     = LW'(i);
                any_queued = 1'b1;
            end
        end
    end

    always_comb begin
        if (s_data.job_priority == '0) begin
            arr_lv = '0;
        end else if ({1'b0, s_data.job_priority} > 4'(LEVELS)) begin
            arr_lv = LV_LAST;
        end else begin
            arr_lv = LW'(s_data.job_priority - 1'b1);
        end
    end

    assign arr_ok = (time_reg <= arrival_cutoff) && (count_reg[arr_lv] < CNT_MAX);

    assign promote = (wait_reg[rd_id] >= aging_threshold)
                  && (count_reg[lv_reg - 1'b1] < CNT_MAX);
    assign dst_lv  = promote ? lv_reg - 1'b1 : lv_reg;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = {arr_lv, wrap_ptr((PW+1)'(head_reg[arr_lv]) + (PW+1)'(count_reg[arr_lv]))};
        ram_wdata = s_data.job_id;
        if (cmd.arrive) begin
            ram_we = arr_ok;
        end else if (cmd.prom_wb) begin
            ram_we    = 1'b1;
            ram_waddr = {dst_lv,
                         wrap_ptr((PW+1)'(head_reg[dst_lv]) + (PW+1)'(count_reg[dst_lv]))};
            ram_wdata = rd_id;
        end
    end

    always_comb begin
        if (cmd.pick_rd) begin
            ram_raddr = {sel_lv, head_reg[sel_lv]};
        end else if (cmd.age_rd) begin
            ram_raddr = {lv_reg, wrap_ptr((PW+1)'(head_reg[lv_reg]) + (PW+1)'(k_reg))};
        end else begin
            ram_raddr = {lv_reg, head_reg[lv_reg]};
        end
    end

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        wait_next  = wait_reg;
        if (cmd.arrive && arr_ok) begin
            count_next[arr_lv]       = count_reg[arr_lv] + 1'b1;
            wait_next[s_data.job_id] = '0;
        end
        if (cmd.pick_wb) begin
            head_next[sel_lv]  = wrap_ptr((PW+1)'(head_reg[sel_lv]) + 1'b1);
            count_next[sel_lv] = count_reg[sel_lv] - 1'b1;
        end
        if (cmd.age_wb && wait_reg[rd_id] != WAIT_MAX) begin
            wait_next[rd_id] = wait_reg[rd_id] + 1'b1;
        end
        if (cmd.prom_wb) begin
            head_next[lv_reg] = wrap_ptr((PW+1)'(head_reg[lv_reg]) + 1'b1);
            if (promote) begin
                count_next[lv_reg]        = count_reg[lv_reg] - 1'b1;
                count_next[lv_reg - 1'b1] = count_reg[lv_reg - 1'b1] + 1'b1;
                wait_next[rd_id]          = '0;
            end
        end
    end

    assign quanta_dec = quanta_reg - 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LEVELS; i++) begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            for (int i = 0; i < ID_SPACE; i++) begin
                wait_reg[i] <= '0;
            end
            busy_reg     <= 1'b0;
            cur_reg      <= '0;
            quanta_reg   <= '0;
            time_reg     <= '0;
            started_reg  <= 1'b0;
            res_busy_reg <= 1'b0;
            res_done_reg <= 1'b0;
            lv_reg       <= '0;
            k_reg        <= '0;
            n_reg        <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
            wait_reg  <= wait_next;
            if (cmd.tick_start) begin
                started_reg <= 1'b0;
                lv_reg      <= '0;
                k_reg       <= '0;
            end
            if (cmd.pick_wb) begin
                cur_reg     <= rd_id;
                quanta_reg  <= rt_reg[rd_id];
                busy_reg    <= 1'b1;
                started_reg <= 1'b1;
            end
            if (cmd.run) begin
                res_busy_reg <= busy_reg;
                res_done_reg <= busy_reg && (quanta_dec == '0);
                if (busy_reg) begin
                    quanta_reg <= quanta_dec;
                    busy_reg   <= (quanta_dec != '0);
                end
            end
            if (cmd.age_wb) begin
                k_reg <= k_reg + 1'b1;
            end
            if (cmd.age_next_lv) begin
                k_reg <= '0;
                if (lv_reg == LV_LAST) begin
                    lv_reg <= LW'(1);
                    n_reg  <= count_reg[1];
                end else begin
                    lv_reg <= lv_reg + 1'b1;
                end
            end
            if (cmd.prom_wb) begin
                n_reg <= n_reg - 1'b1;
            end
            if (cmd.prom_next_lv) begin
                lv_reg <= lv_reg + 1'b1;
                n_reg  <= count_reg[lv_reg + 1'b1];
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
                if (time_reg != TIME_MAX) begin
                    time_reg <= time_reg + 1'b1;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.arrive && arr_ok) begin
            rt_reg[s_data.job_id] <= s_data.job_runtime;
        end
        if (cmd.out_load) begin
            m_data_reg.tick_time     <= time_reg;
            m_data_reg.cpu_busy      <= res_busy_reg;
            m_data_reg.running_job   <= res_busy_reg ? cur_reg : '0;
            m_data_reg.job_started   <= res_busy_reg && started_reg;
            m_data_reg.job_completed <= res_done_reg;
        end
    end

    assign stat.is_tick   = (s_data.command == CMD_TICK);
    assign stat.need_pick = !busy_reg && any_queued;
    assign stat.age_more  = (k_reg < count_reg[lv_reg]);
    assign stat.prom_more = (n_reg != '0);
    assign stat.lv_last   = (lv_reg == LV_LAST);
    assign stat.out_free  = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `PSA_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, count_reg[0] <= CNT_MAX)
    `PSA_ASSERT_NEXT(a_pick_busy, aclk, aresetn, cmd.pick_wb, busy_reg)
    `PSA_ASSERT_IMPL(a_load_free, aclk, aresetn, cmd.out_load, !m_valid_reg || m_ready)
    `PSA_ASSERT_NEXT(a_time_step, aclk, aresetn, cmd.out_load && time_reg != TIME_MAX,
                     time_reg == $past(time_reg) + 1'b1)

endmodule
